/* rtl/pcxd_pkg.sv */
// Shared types and constants for the PCX run-length palette decoder.
// No dependencies; imported by pcxd_palette and pcx_rle_palette_decoder.
`default_nettype none

package pcxd_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int RUN_BITS          = 6;
	localparam int DIM_W             = 16;
	localparam int POS_W             = 32;
	localparam int CFG_IDX_W         = 1;

	localparam logic [7:0] MARK_MASK  = 8'hC0;
	localparam logic [7:0] COUNT_MASK = 8'h3F;
	localparam logic [7:0] OPAQUE     = 8'hFF;

	typedef enum logic [1:0] {
		REQ_DATA  = 2'd0,
		REQ_PAL   = 2'd1,
		REQ_START = 2'd2
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	typedef struct packed {
		logic       en;
		logic [7:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pal_wr_t;

	typedef struct packed {
		logic       en;
		logic [7:0] index;
	} pal_rd_t;

endpackage

`default_nettype wire

/* rtl/pcxd_palette.sv */
// Palette RAM with one write and one registered read port, plus color-index formatting.
// Depends on pcxd_pkg.
`default_nettype none

module pcxd_palette
	import pcxd_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  wire     clk,
	input  pal_wr_t wr,
	input  pal_rd_t rd,
	output rgba_t   color
);

	localparam int         AW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

	logic [23:0] mem [PALETTE_DEPTH];
	logic [23:0] rd_data_q;
	logic [7:0]  rd_index_q;
	logic        wr_ok;
	logic        rd_ok;

	assign wr_ok = {1'b0, wr.index} < DEPTH9;
	assign rd_ok = {1'b0, rd_index_q} < DEPTH9;

	always_ff @(posedge clk) begin
		if (wr.en && wr_ok) begin
			mem[wr.index[AW-1:0]] <= {wr.red, wr.green, wr.blue};
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q  <= mem[rd.index[AW-1:0]];
			rd_index_q <= rd.index;
		end
	end

	// index 0 is transparent black; out-of-range index is opaque black
	always_comb begin
		color = '0;
		if (rd_index_q != 8'd0) begin
			color.alpha = OPAQUE;
			if (rd_ok) begin
				color.red   = rd_data_q[23:16];
				color.green = rd_data_q[15:8];
				color.blue  = rd_data_q[7:0];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/pcx_rle_palette_decoder.sv */
// Top level of the PCX run-length decoder: request decode, run sequencer, pixel output register.
// Depends on pcxd_pkg and pcxd_palette.
//
//   channel   direction  handshake              payload
//   req       in         req_valid/req_ready    req_type, data_byte, pal_index, pal_*
//   pix       out        pix_valid/pix_ready    red, green, blue, alpha, pixel_pos, ...
//   cfg       in         cfg_we                 cfg_index, cfg_data
//
// A literal byte is accepted together with its palette read, then gives one pixel; the
// color byte of a run of N pixels is accepted likewise, then the run gives N pixels.
// The run sequencer emits one pixel per cycle into the output register; a stall on
// pix_ready holds the sequencer. Next request is taken once the last pixel is loaded.
// Reset clears counter, pending marker and sizes to 1x1; palette contents stay unknown.
`default_nettype none

module pcx_rle_palette_decoder
	import pcxd_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,

	input  wire                  req_valid,
	output logic                 req_ready,
	input  wire  [1:0]           req_type,
	input  wire  [7:0]           data_byte,
	input  wire  [7:0]           pal_index,
	input  wire  [7:0]           pal_red,
	input  wire  [7:0]           pal_green,
	input  wire  [7:0]           pal_blue,

	output logic                 pix_valid,
	input  wire                  pix_ready,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue,
	output logic [7:0]           alpha,
	output logic [POS_W-1:0]     pixel_pos,
	output logic                 run_last,
	output logic                 image_full,

	input  wire                  cfg_we,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [DIM_W-1:0]     cfg_data
);

	state_t              state_q, state_d;
	logic [DIM_W-1:0]    width_q, height_q;
	logic [POS_W-1:0]    total;
	logic [POS_W-1:0]    cnt_q;
	logic [POS_W-1:0]    cnt_inc;
	logic                pend_q, pend_d;
	logic [RUN_BITS-1:0] pend_cnt_q, pend_cnt_d;
	logic [RUN_BITS-1:0] remain_q, remain_d;

	logic                accept;
	logic                is_data;
	logic                live;
	logic                marker;
	logic                start_run;
	logic                emit;
	logic                run_end;
	logic                cnt_clear;

	pal_wr_t             pal_wr;
	pal_rd_t             pal_rd;
	rgba_t               color;

	assign accept  = req_valid && req_ready;
	assign is_data = accept && (req_type == REQ_DATA);
	assign total   = POS_W'(width_q) * POS_W'(height_q);
	assign live    = cnt_q < total;
	assign marker  = (data_byte & MARK_MASK) == MARK_MASK;
	assign cnt_inc = cnt_q + POS_W'(1);
	assign run_end = (remain_q == RUN_BITS'(1)) || (cnt_inc == total);

	// image sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default:    ;
				endcase
			end
		end
	end

	assign pal_wr.en    = accept && (req_type == REQ_PAL);
	assign pal_wr.index = pal_index;
	assign pal_wr.red   = pal_red;
	assign pal_wr.green = pal_green;
	assign pal_wr.blue  = pal_blue;

	always_comb begin
		state_d    = state_q;
		pend_d     = pend_q;
		pend_cnt_d = pend_cnt_q;
		remain_d   = remain_q;
		req_ready  = 1'b0;
		start_run  = 1'b0;
		emit       = 1'b0;
		cnt_clear  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (accept && (req_type == REQ_START)) begin
					cnt_clear = 1'b1;
					pend_d    = 1'b0;
				end
				if (is_data && live) begin
					if (pend_q) begin
						pend_d    = 1'b0;
						start_run = pend_cnt_q != '0;
						remain_d  = pend_cnt_q;
					end else if (marker) begin
						pend_d     = 1'b1;
						pend_cnt_d = data_byte[RUN_BITS-1:0];
					end else begin
						start_run = 1'b1;
						remain_d  = RUN_BITS'(1);
					end
				end
				if (start_run) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				emit = !pix_valid || pix_ready;
				if (emit) begin
					remain_d = remain_q - RUN_BITS'(1);
					if (run_end) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign pal_rd.en    = start_run;
	assign pal_rd.index = data_byte;

	pcxd_palette #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.wr    (pal_wr),
		.rd    (pal_rd),
		.color (color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			pend_cnt_q <= '0;
			remain_q   <= '0;
			pix_valid  <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_q     <= pend_d;
			pend_cnt_q <= pend_cnt_d;
			remain_q   <= remain_d;
			if (cnt_clear) begin
				cnt_q <= '0;
			end else if (emit) begin
				cnt_q <= cnt_inc;
			end
			if (emit) begin
				pix_valid <= 1'b1;
			end else if (pix_ready) begin
				pix_valid <= 1'b0;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (emit) begin
			red        <= color.red;
			green      <= color.green;
			blue       <= color.blue;
			alpha      <= color.alpha;
			pixel_pos  <= cnt_q;
			run_last   <= run_end;
			image_full <= cnt_inc == total;
		end
	end

	a_run_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (remain_q != '0))
		else $error("run state with no pixels left");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> pix_valid)
		else $error("emitted pixel not presented");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (cnt_q == $past(cnt_q) + POS_W'(1)))
		else $error("pixel counter did not advance by one");

	a_full_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && image_full) |-> run_last)
		else $error("image end pixel not marked last of its run");

	a_no_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		start_run |=> !req_ready)
		else $error("request taken while a run is starting");

endmodule

`default_nettype wire

/* bench/pcxd_pixel_checker.sv */
// Pixel checker for pcx_rle_palette_decoder: watches the request, pixel and config ports,
// predicts every pixel the decoder should emit, and compares each accepted pixel beat.
// Depends on pcxd_pkg for request codes, register indexes, masks and widths.
module pcxd_pixel_checker
	import pcxd_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [DIM_W-1:0]     cfg_data,
	input  wire                  req_valid,
	input  wire                  req_ready,
	input  wire  [1:0]           req_type,
	input  wire  [7:0]           data_byte,
	input  wire  [7:0]           pal_index,
	input  wire  [7:0]           pal_red,
	input  wire  [7:0]           pal_green,
	input  wire  [7:0]           pal_blue,
	input  wire                  pix_valid,
	input  wire                  pix_ready,
	input  wire  [7:0]           red,
	input  wire  [7:0]           green,
	input  wire  [7:0]           blue,
	input  wire  [7:0]           alpha,
	input  wire  [POS_W-1:0]     pixel_pos,
	input  wire                  run_last,
	input  wire                  image_full,
	output int                   pixels_due,
	output int                   mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		rgba_t            color;
		logic [POS_W-1:0] pos;
		logic             last;
		logic             full;
	} pixel_t;

	logic [23:0]         pal_rgb [256];
	logic [DIM_W-1:0]    img_w;
	logic [DIM_W-1:0]    img_h;
	logic [POS_W-1:0]    pos_next;
	logic                run_armed;
	logic [RUN_BITS-1:0] run_len;
	pixel_t              expected_pixels [$];
	int                  errors = 0;

	task automatic flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%t %s", $realtime, msg);
	endtask

	// Emit up to count pixels of one color, cut short at the end of the image.
	task automatic emit_run(logic [7:0] color_idx, int count);
		logic [POS_W-1:0] total;
		rgba_t            shade;
		pixel_t           px;
		int               n;
		total = POS_W'(img_w) * POS_W'(img_h);
		shade = (color_idx == 8'd0) ? '0 : {pal_rgb[color_idx], OPAQUE};
		for (n = 0; n < count && pos_next < total; n++) begin
			px.color = shade;
			px.pos   = pos_next;
			px.full  = (pos_next + 1 == total);
			px.last  = (n == count - 1) || px.full;
			expected_pixels = {expected_pixels, px};
			pos_next++;
		end
	endtask

	task automatic decode_request();
		logic [POS_W-1:0] total;
		total = POS_W'(img_w) * POS_W'(img_h);
		case (req_type_t'(req_type))
			REQ_PAL: pal_rgb[pal_index] = {pal_red, pal_green, pal_blue};
			REQ_START: begin
				pos_next  = '0;
				run_armed = 1'b0;
				run_len   = '0;
			end
			REQ_DATA: begin
				// once the image is full, data is dropped and a pending marker survives
				if (pos_next < total) begin
					if (run_armed) begin
						run_armed = 1'b0;
						emit_run(data_byte, int'(run_len));
					end else if ((data_byte & MARK_MASK) == MARK_MASK) begin
						run_armed = 1'b1;
						run_len   = RUN_BITS'(data_byte & COUNT_MASK);
					end else begin
						emit_run(data_byte, 1);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_pixel();
		pixel_t got;
		pixel_t want;
		got = {red, green, blue, alpha, pixel_pos, run_last, image_full};
		if (expected_pixels.size() == 0) begin
			flag_error($sformatf("unexpected pixel: rgba=%h pos=%0d last=%b full=%b",
				got.color, got.pos, got.last, got.full));
		end else begin
			want = expected_pixels.pop_front();
			if (got !== want)
				flag_error($sformatf({"pixel mismatch: exp rgba=%h pos=%0d last=%b full=%b,",
					" got rgba=%h pos=%0d last=%b full=%b"},
					want.color, want.pos, want.last, want.full,
					got.color, got.pos, got.last, got.full));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w     = 1;
			img_h     = 1;
			pos_next  = '0;
			run_armed = 1'b0;
			run_len   = '0;
			expected_pixels.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_reg_t'(cfg_index) == CFG_WIDTH)
					img_w = cfg_data;
				else
					img_h = cfg_data;
			end
			if (req_valid && req_ready)
				decode_request();
			if (pix_valid && pix_ready)
				check_pixel();
		end
		pixels_due     <= expected_pixels.size();
		mismatch_count <= errors;
	end

endmodule

/* bench/tb.sv */
// Top of the pcx_rle_palette_decoder bench: clock, reset, request stimulus, config writes,
// pixel back-pressure and verdict. Depends on pcxd_pkg, the decoder RTL and pcxd_pixel_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pcxd_pkg::*;

	localparam int IDLE_PCT       = 24;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 8;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 5;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic [1:0]           req_type = REQ_DATA;
	logic [7:0]           data_byte = '0;
	logic [7:0]           pal_index = '0;
	logic [7:0]           pal_red = '0;
	logic [7:0]           pal_green = '0;
	logic [7:0]           pal_blue = '0;
	logic                 pix_valid;
	logic                 pix_ready = 1'b0;
	logic [7:0]           red;
	logic [7:0]           green;
	logic [7:0]           blue;
	logic [7:0]           alpha;
	logic [POS_W-1:0]     pixel_pos;
	logic                 run_last;
	logic                 image_full;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
	logic [DIM_W-1:0]     cfg_data = '0;

	int pixels_due;
	int mismatch_count;
	int quiet_cycles = 0;
	bit steady = 1'b0;
	bit pal_known [256];

	always #5 clk = ~clk;

	pcx_rle_palette_decoder DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
		.data_byte(data_byte), .pal_index(pal_index),
		.pal_red(pal_red), .pal_green(pal_green), .pal_blue(pal_blue),
		.pix_valid(pix_valid), .pix_ready(pix_ready),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.pixel_pos(pixel_pos), .run_last(run_last), .image_full(image_full),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pcxd_pixel_checker watch (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
		.data_byte(data_byte), .pal_index(pal_index),
		.pal_red(pal_red), .pal_green(pal_green), .pal_blue(pal_blue),
		.pix_valid(pix_valid), .pix_ready(pix_ready),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.pixel_pos(pixel_pos), .run_last(run_last), .image_full(image_full),
		.pixels_due(pixels_due), .mismatch_count(mismatch_count)
	);

	always @(posedge clk)
		pix_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (req_valid && req_ready) || (pix_valid && pix_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// valid stays up after the beat; the next call either idles it or loads a new beat
	task automatic push_request(req_type_t kind, logic [7:0] code, logic [7:0] idx,
			logic [7:0] r, logic [7:0] g, logic [7:0] b);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		data_byte <= code;
		pal_index <= idx;
		pal_red   <= r;
		pal_green <= g;
		pal_blue  <= b;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic write_palette(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		push_request(REQ_PAL, 8'($urandom_range(0, 255)), idx, r, g, b);
		pal_known[idx] = 1'b1;
	endtask

	// Any nonzero byte may end up as a color index, so its entry is loaded first.
	task automatic feed_byte(logic [7:0] code);
		if (code != 8'd0 && !pal_known[code])
			write_palette(code, 8'($urandom), 8'($urandom), 8'($urandom));
		push_request(REQ_DATA, code, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic new_image();
		push_request(REQ_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pixels_due != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_image_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly well-formed runs and literals sized to the image, plus palette
	// updates, stray bytes, restarts and an occasional pause for the output to drain.
	task automatic random_phase(int unsigned total, int budget);
		int unsigned planned;
		int          pick;
		logic [5:0]  cnt;
		logic [7:0]  color;
		planned = 0;
		new_image();
		while (budget > 0) begin
			if (planned >= total && $urandom_range(0, 2) == 0) begin
				new_image();
				planned = 0;
				budget--;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				cnt   = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, 6));
				color = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
				if (planned < total)
					budget -= 2;
				feed_byte(MARK_MASK | 8'(cnt));
				feed_byte(color);
				planned += cnt;
			end else if (pick < 75) begin
				if (planned < total)
					budget--;
				feed_byte(8'($urandom_range(0, 8'hBF)));
				planned++;
			end else if (pick < 85) begin
				write_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				budget--;
			end else if (pick < 93) begin
				if (planned < total)
					budget--;
				feed_byte(8'($urandom_range(0, 255)));
			end else if (pick < 97) begin
				new_image();
				planned = 0;
				budget--;
			end else begin
				settle();
			end
		end
	endtask

	initial begin
		int unsigned w;
		int unsigned h;
		int          ph;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size is 1x1
		write_palette(8'h00, 8'hFF, 8'hFF, 8'hFF);
		write_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		write_palette(8'h01, 8'h00, 8'h00, 8'h00);
		feed_byte(8'h01);
		feed_byte(8'h01);          // image already full, dropped
		new_image();
		feed_byte(8'hC5);
		feed_byte(8'hFF);          // run cut at the single pixel

		set_image_size(16'd4, 16'd4);
		new_image();
		feed_byte(8'h00);          // transparent
		feed_byte(8'hBF);          // largest literal
		feed_byte(8'hC0);          // zero-length run
		feed_byte(8'h01);
		feed_byte(8'hC3);
		write_palette(8'h80, 8'h12, 8'h34, 8'h56);  // marker stays pending
		feed_byte(8'h80);
		feed_byte(8'hFF);          // 63-pixel run, cut at the image end
		feed_byte(8'h00);
		feed_byte(8'hC2);          // full: ignored
		feed_byte(8'h01);
		new_image();
		feed_byte(8'hC2);
		new_image();               // drops the pending marker
		feed_byte(8'h01);

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					w = 65535;
					h = 65535;
				end
				1: begin
					w = 1;
					h = 1;
				end
				2: begin
					w = 65535;
					h = 1;
				end
				default: begin
					w = $urandom_range(1, 10);
					h = $urandom_range(1, 8);
				end
			endcase
			set_image_size(DIM_W'(w), DIM_W'(h));
			steady = (ph == 4);
			random_phase(w * h, PHASE_ITEMS);
		end
		steady = 1'b0;
		settle();

		if (mismatch_count == 0 && pixels_due == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
